[design/led_fire_effect_frame_defines.svh]
// Assertion macros for the LED fire effect frame generator.
// Included by the top level; needs a clk and an active-low rst_n in scope.
`ifndef LED_FIRE_EFFECT_FRAME_DEFINES_SVH
`define LED_FIRE_EFFECT_FRAME_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LFEF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LFEF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LFEF_ASSERT_IMPL(lbl, ante, cons, msg)
`define LFEF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[design/lfef_pkg.sv]
// Package for the LED fire effect frame generator: sizes, register codes,
// sequencer states, the LFSR step function and the heat scaling table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lfef_pkg;

  localparam int MAX_LEDS = 64;
  localparam int MIN_LEDS = 8;
  localparam int ADDR_W   = $clog2(MAX_LEDS);
  localparam int CNT_W    = $clog2(MAX_LEDS + 1);

  localparam logic [15:0] SEED_DEFAULT = 16'd44257;
  localparam logic [15:0] LFSR_TAPS    = 16'hB400;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_COOLING = 2'd0;
  localparam logic [1:0] REG_SPARK   = 2'd1;
  localparam logic [1:0] REG_NUMLEDS = 2'd2;
  localparam logic [1:0] REG_SEED    = 2'd3;

  localparam logic [7:0] COOLING_RST = 8'd20;
  localparam logic [7:0] SPARK_RST   = 8'd20;
  localparam logic [6:0] NUMLEDS_RST = 7'd60;

  localparam int DIV_STEPS = 12;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_COOL_RD,
    ST_COOL_WR,
    ST_DRIFT_RA,
    ST_DRIFT_RB,
    ST_DRIFT_WR,
    ST_SPARK_CHK,
    ST_SPARK_SEL,
    ST_SPARK_WR,
    ST_OUT_RD,
    ST_OUT_LD
  } fsm_state_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] s;
    s = {1'b0, v[15:1]};
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

  // Heat 0..255 scaled to 0..191, rounded half up.
  localparam int HeatScaleMul = 382;
  localparam int HeatScaleAdd = 255;
  localparam int HeatScaleDiv = 510;

  typedef logic [7:0] heat_lut_t [256];

  function automatic heat_lut_t build_heat_lut();
    heat_lut_t lut;
    for (int k = 0; k < 256; k++) begin
      lut[k] = 8'((k * HeatScaleMul + HeatScaleAdd) / HeatScaleDiv);
    end
    return lut;
  endfunction

  localparam heat_lut_t HEAT_LUT = build_heat_lut();

endpackage

`default_nettype wire

[design/led_fire_effect_frame.sv]
// A frame request is taken only in the idle state. A frame runs a 12-step divider, then one
// pass per phase over the heat memory for the n cells in use (n = 8..64), a spark phase when
// a spark fires, and the output pass; sink stalls lengthen the frame.
// One frame at a time; pixels leave one by one and hold in the output register until taken.
// Reset (synchronous, active low): heat cells read as zero through per-cell valid bits,
// registers return to cooling 20, spark 20, 60 cells, seed 44257; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "led_fire_effect_frame_defines.svh"

module led_fire_effect_frame (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Frame request channel.
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_frame_request,
  // Pixel channel.
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [lfef_pkg::ADDR_W-1:0]      out_pixel_index,
  output logic [7:0]                       out_red,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_blue,
  output logic                             out_last_pixel,
  // APB-style configuration port.
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [3:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import lfef_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while the block is idle; the block
  // does not enforce this. The sequencer reads these directly without a copy at frame start.
  // ---------------------------------------------------------------------------
  logic [7:0]  cooling_r;
  logic [7:0]  spark_r;
  logic [6:0]  num_leds_r;
  logic [15:0] seed_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_idx)
      REG_COOLING: prdata = {24'd0, cooling_r};
      REG_SPARK:   prdata = {24'd0, spark_r};
      REG_NUMLEDS: prdata = {25'd0, num_leds_r};
      REG_SEED:    prdata = {16'd0, seed_r};
      default:     prdata = 32'd0;
    endcase
  end

  // The strip length is clamped to the supported range before any use.
  logic [CNT_W-1:0]  n_eff;
  logic [ADDR_W-1:0] last_idx;

  always_comb begin
    if (num_leds_r < 7'(MIN_LEDS)) begin
      n_eff = CNT_W'(MIN_LEDS);
    end else if (num_leds_r > 7'(MAX_LEDS)) begin
      n_eff = CNT_W'(MAX_LEDS);
    end else begin
      n_eff = CNT_W'(num_leds_r);
    end
  end

  assign last_idx = ADDR_W'(n_eff - CNT_W'(1));

  // ---------------------------------------------------------------------------
  // Heat memory: one write port and one registered read port. A valid bit per
  // cell makes a never-written cell read as zero, which stands in for the
  // all-zero reset of the store.
  // ---------------------------------------------------------------------------
  logic [7:0]          heat_mem [MAX_LEDS];
  logic [MAX_LEDS-1:0] heat_vld_r;
  logic [7:0]          rd_data_r;
  logic                rd_vld_r;
  logic [ADDR_W-1:0]   mem_raddr;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [7:0]          mem_wdata;
  logic [7:0]          heat_rd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heat_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= heat_mem[mem_raddr];
    rd_vld_r  <= heat_vld_r[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heat_vld_r <= '0;
    end else if (mem_we) begin
      heat_vld_r[mem_waddr] <= 1'b1;
    end
  end

  assign heat_rd = rd_vld_r ? rd_data_r : 8'd0;

  // ---------------------------------------------------------------------------
  // Sequencer state and working registers.
  // ---------------------------------------------------------------------------
  fsm_state_t        state_r, state_nxt;
  logic [15:0]       lfsr_r, lfsr_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [3:0]        div_cnt_r, div_cnt_nxt;
  logic [6:0]        rem_r, rem_nxt;
  logic [11:0]       quo_r, quo_nxt;
  logic [8:0]        limit_r, limit_nxt;
  logic [7:0]        a_r, a_nxt;
  logic [2:0]        spark_idx_r, spark_idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_pixel_index_r;
  logic [7:0]        out_red_r, out_green_r, out_blue_r;
  logic              out_last_pixel_r;
  logic              out_load;
  logic [7:0]        red_nxt, green_nxt, blue_nxt;
  logic              last_nxt;

  // One shared draw unit: the stepped LFSR value times the draw range, upper
  // bits taken. Each state that draws steps the LFSR exactly once.
  logic        draw_en;
  logic [8:0]  draw_range;
  logic [15:0] draw_r;
  logic [24:0] draw_prod;
  logic [8:0]  draw_val;

  assign draw_r    = lfsr_step(lfsr_r);
  assign draw_prod = {9'd0, draw_r} * {16'd0, draw_range};
  assign draw_val  = draw_prod[24:16];

  // Divider step for the cooling limit, cooling*10/n, one quotient bit per cycle.
  logic [11:0] dividend;
  logic [7:0]  rem_sh;
  logic        div_ge;

  assign dividend = ({4'd0, cooling_r} << 3) + ({4'd0, cooling_r} << 1);
  assign rem_sh   = {rem_r, quo_r[11]};
  assign div_ge   = (rem_sh >= {1'b0, n_eff});

  // Cooling: subtract the draw and floor at zero.
  logic [7:0] cooled;
  assign cooled = ({1'b0, heat_rd} < draw_val) ? 8'd0 : (heat_rd - draw_val[7:0]);

  // Drift: (below + 2*two_below) / 3, the divide done as a multiply by
  // 683/2048, which is exact for sums below 1024.
  logic [9:0]  drift_sum;
  logic [19:0] drift_prod;
  logic [7:0]  drift_val;

  assign drift_sum  = {2'd0, a_r} + {1'b0, heat_rd, 1'b0};
  assign drift_prod = {10'd0, drift_sum} * 20'd683;
  assign drift_val  = drift_prod[18:11];

  // Spark: 160 plus a draw over 95 values, added with saturation.
  logic [7:0] spark_add;
  logic [8:0] spark_sum;
  logic [7:0] spark_val;

  assign spark_add = 8'd160 + draw_val[7:0];
  assign spark_sum = {1'b0, heat_rd} + {1'b0, spark_add};
  assign spark_val = spark_sum[8] ? 8'hFF : spark_sum[7:0];

  // Color ramp: scale heat to 0..191 by table, then pick the segment.
  logic [7:0] heat_t;
  logic [7:0] ramp;

  assign heat_t = HEAT_LUT[heat_rd];
  assign ramp   = {heat_t[5:0], 2'b00};

  always_comb begin
    if (heat_t > 8'h80) begin
      red_nxt = 8'hFF; green_nxt = 8'hFF; blue_nxt = ramp;
    end else if (heat_t > 8'h40) begin
      red_nxt = 8'hFF; green_nxt = ramp;  blue_nxt = 8'd0;
    end else begin
      red_nxt = ramp;  green_nxt = 8'd0;  blue_nxt = 8'd0;
    end
  end

  assign last_nxt = (idx_r == last_idx);

  // ---------------------------------------------------------------------------
  // Next state and datapath control. A frame runs: divide, cooling pass
  // (read, write per cell), drift pass from the top down (read two cells
  // below, write), optional spark (three draws), and the output pass.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    div_cnt_nxt   = div_cnt_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    limit_nxt     = limit_r;
    a_nxt         = a_r;
    spark_idx_nxt = spark_idx_r;
    in_ready      = 1'b0;
    mem_raddr     = idx_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = cooled;
    draw_en       = 1'b0;
    draw_range    = limit_r;
    out_load      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_frame_request) begin
          quo_nxt     = dividend;
          rem_nxt     = 7'd0;
          div_cnt_nxt = 4'd0;
          state_nxt   = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt     = div_ge ? 7'(rem_sh - {1'b0, n_eff}) : rem_sh[6:0];
        quo_nxt     = {quo_r[10:0], div_ge};
        div_cnt_nxt = div_cnt_r + 4'd1;
        if (div_cnt_r == 4'(DIV_STEPS - 1)) begin
          limit_nxt = quo_nxt[8:0] + 9'd2;
          idx_nxt   = '0;
          state_nxt = ST_COOL_RD;
        end
      end
      ST_COOL_RD: begin
        state_nxt = ST_COOL_WR;
      end
      ST_COOL_WR: begin
        draw_en    = 1'b1;
        draw_range = limit_r;
        mem_we     = 1'b1;
        mem_wdata  = cooled;
        if (idx_r == last_idx) begin
          state_nxt = ST_DRIFT_RA;
        end else begin
          idx_nxt   = idx_r + ADDR_W'(1);
          state_nxt = ST_COOL_RD;
        end
      end
      ST_DRIFT_RA: begin
        mem_raddr = idx_r - ADDR_W'(1);
        state_nxt = ST_DRIFT_RB;
      end
      ST_DRIFT_RB: begin
        mem_raddr = idx_r - ADDR_W'(2);
        a_nxt     = heat_rd;
        state_nxt = ST_DRIFT_WR;
      end
      ST_DRIFT_WR: begin
        mem_we    = 1'b1;
        mem_wdata = drift_val;
        if (idx_r == ADDR_W'(2)) begin
          state_nxt = ST_SPARK_CHK;
        end else begin
          idx_nxt   = idx_r - ADDR_W'(1);
          state_nxt = ST_DRIFT_RA;
        end
      end
      ST_SPARK_CHK: begin
        draw_en    = 1'b1;
        draw_range = 9'd255;
        if (draw_val < {1'b0, spark_r}) begin
          state_nxt = ST_SPARK_SEL;
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_OUT_RD;
        end
      end
      ST_SPARK_SEL: begin
        draw_en       = 1'b1;
        draw_range    = 9'd7;
        spark_idx_nxt = draw_val[2:0];
        mem_raddr     = ADDR_W'(draw_val[2:0]);
        state_nxt     = ST_SPARK_WR;
      end
      ST_SPARK_WR: begin
        draw_en    = 1'b1;
        draw_range = 9'd95;
        mem_we     = 1'b1;
        mem_waddr  = ADDR_W'(spark_idx_r);
        mem_wdata  = spark_val;
        idx_nxt    = '0;
        state_nxt  = ST_OUT_RD;
      end
      ST_OUT_RD: begin
        state_nxt = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        // The read address stays on this cell, so the read data holds while
        // the output register is still occupied.
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          if (last_nxt) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + ADDR_W'(1);
            state_nxt = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cfg_wr && (cfg_idx == REG_SEED)) begin
      lfsr_nxt = (pwdata[15:0] == 16'd0) ? SEED_DEFAULT : pwdata[15:0];
    end else if (draw_en) begin
      lfsr_nxt = draw_r;
    end else begin
      lfsr_nxt = lfsr_r;
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lfsr_r      <= SEED_DEFAULT;
      out_valid_r <= 1'b0;
      cooling_r   <= COOLING_RST;
      spark_r     <= SPARK_RST;
      num_leds_r  <= NUMLEDS_RST;
      seed_r      <= SEED_DEFAULT;
    end else begin
      state_r     <= state_nxt;
      lfsr_r      <= lfsr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_COOLING: cooling_r  <= pwdata[7:0];
          REG_SPARK:   spark_r    <= pwdata[7:0];
          REG_NUMLEDS: num_leds_r <= pwdata[6:0];
          REG_SEED:    seed_r     <= pwdata[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Working and payload registers need no reset.
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    div_cnt_r   <= div_cnt_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    limit_r     <= limit_nxt;
    a_r         <= a_nxt;
    spark_idx_r <= spark_idx_nxt;
    if (out_load) begin
      out_pixel_index_r <= idx_r;
      out_red_r         <= red_nxt;
      out_green_r       <= green_nxt;
      out_blue_r        <= blue_nxt;
      out_last_pixel_r  <= last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_pixel_index_r;
  assign out_red         = out_red_r;
  assign out_green       = out_green_r;
  assign out_blue        = out_blue_r;
  assign out_last_pixel  = out_last_pixel_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `LFEF_ASSERT_IMPL(a_lfsr_nonzero, 1'b1, lfsr_r != 16'd0, "LFSR reached the locked zero state")
  `LFEF_ASSERT_IMPL(a_spark_range, state_r == ST_SPARK_WR, spark_idx_r < 3'd7, "spark cell out of range")
  `LFEF_ASSERT_IMPL(a_pixel_range, out_valid_r, out_pixel_index_r <= last_idx, "pixel index beyond strip")
  `LFEF_ASSERT_NEXT(a_frame_end, out_load && last_nxt, state_r == ST_IDLE, "sequencer missed frame end")

endmodule

`default_nettype wire
